// ===== hdl/wsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and pipeline record types for the window deviation block.
package wsd_pkg;

  localparam int SUM_W       = 28;              // integral image corner width
  localparam int SQ_W        = 36;              // squared integral corner width
  localparam int DIM_W       = 11;              // window side width
  localparam int DEV_W       = 8;               // result width
  localparam int N_W         = 2 * DIM_W;       // pixel count width
  localparam int SBOX_W      = SUM_W + 2;       // signed box sum
  localparam int QBOX_W      = SQ_W + 2;        // signed box squared sum
  localparam int SMAG_W      = SUM_W + 1;       // box sum magnitude
  localparam int QMAG_W      = SQ_W + 1;        // box squared sum magnitude
  localparam int MM_W        = 2 * SMAG_W;      // mean squared
  localparam int DIFF_W      = QMAG_W + MM_W - QMAG_W + 1; // signed variance
  localparam int VAR_W       = 2 * DEV_W;       // variance below saturation
  localparam int DIV_STAGES  = QMAG_W;          // one quotient bit per stage
  localparam int SQRT_STAGES = DEV_W;           // one root bit per stage

  localparam logic [DEV_W-1:0]  DEV_MAX   = '1;
  localparam logic [DEV_W-1:0]  DEV_ONE   = DEV_W'(1);
  localparam logic [DIFF_W-1:0] SAT_LIMIT = DIFF_W'(255 * 255);

  // Divider stage record: both lanes share the divisor.
  typedef struct packed {
    logic              vld;
    logic              zero;   // pixel count of zero
    logic              neg_q;  // squared box sum negative
    logic [QMAG_W-1:0] sacc;   // box sum dividend shifting into quotient
    logic [N_W-1:0]    srem;
    logic [QMAG_W-1:0] qacc;   // squared sum dividend shifting into quotient
    logic [N_W-1:0]    qrem;
    logic [N_W-1:0]    n;
  } div_t;

  // Root stage record.
  typedef struct packed {
    logic             vld;
    logic             one;     // variance not positive, no pixels or squared box sum negative
    logic             sat;     // variance at least 255 * 255, result forced to the maximum
    logic [VAR_W-1:0] v;
    logic [DEV_W-1:0] r;
  } sq_t;

endpackage

// ===== hdl/window_std_deviation.sv =====
`timescale 1ns / 1ps
// Top level: window standard deviation from integral image corners, fully pipelined.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------
//  command  | start_i, busy_o  | sum_*_i (28b), sq_*_i (36b), win_width/height_i
//  result   | done_o (strobe)  | deviation_o (8b)
//
// One item per cycle through two setup stages, 37 divider stages
// (one quotient bit each, set by the squared sum width), three variance stages,
// eight root stages and the output register.
// busy_o is always low; the pipeline never stalls since results cannot be held.
// Reset clears the valid bits and the divider and root stage records; other payload settles as items flow.
module window_std_deviation (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [wsd_pkg::SUM_W-1:0] sum_top_left_i,
  input  logic [wsd_pkg::SUM_W-1:0] sum_top_right_i,
  input  logic [wsd_pkg::SUM_W-1:0] sum_bottom_left_i,
  input  logic [wsd_pkg::SUM_W-1:0] sum_bottom_right_i,
  input  logic [wsd_pkg::SQ_W-1:0]  sq_top_left_i,
  input  logic [wsd_pkg::SQ_W-1:0]  sq_top_right_i,
  input  logic [wsd_pkg::SQ_W-1:0]  sq_bottom_left_i,
  input  logic [wsd_pkg::SQ_W-1:0]  sq_bottom_right_i,
  input  logic [wsd_pkg::DIM_W-1:0] win_width_i,
  input  logic [wsd_pkg::DIM_W-1:0] win_height_i,
  output logic                      done_o,
  output logic [wsd_pkg::DEV_W-1:0] deviation_o
);

  // ---------------- stage 1: box sums and pixel count ----------------
  logic                              vld1_q;
  logic signed [wsd_pkg::SBOX_W-1:0] box_q, box_d;
  logic signed [wsd_pkg::QBOX_W-1:0] qbox_q, qbox_d;
  logic [wsd_pkg::N_W-1:0]           n_q, n_d;
  logic                              zero_q, zero_d;

  assign busy_o = 1'b0;

  always_comb begin
    box_d  = $signed(wsd_pkg::SBOX_W'(sum_bottom_right_i))
           - ($signed(wsd_pkg::SBOX_W'(sum_top_right_i))
              + $signed(wsd_pkg::SBOX_W'(sum_bottom_left_i)))
           + $signed(wsd_pkg::SBOX_W'(sum_top_left_i));
    qbox_d = $signed(wsd_pkg::QBOX_W'(sq_bottom_right_i))
           - ($signed(wsd_pkg::QBOX_W'(sq_top_right_i))
              + $signed(wsd_pkg::QBOX_W'(sq_bottom_left_i)))
           + $signed(wsd_pkg::QBOX_W'(sq_top_left_i));
    n_d    = wsd_pkg::N_W'(win_width_i) * wsd_pkg::N_W'(win_height_i);
    zero_d = (win_width_i == '0) || (win_height_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q  <= box_d;
    qbox_q <= qbox_d;
    n_q    <= n_d;
    zero_q <= zero_d;
  end

  // ---------------- stage 2: magnitudes into the divider ----------------
  // Truncating division: divide magnitudes, the mean's sign drops out on squaring.
  wsd_pkg::div_t div_pipe [wsd_pkg::DIV_STAGES+1];
  wsd_pkg::div_t div_in_d;
  logic [wsd_pkg::SBOX_W-1:0] box_mag;
  logic [wsd_pkg::QBOX_W-1:0] qbox_mag;

  assign box_mag  = box_q[wsd_pkg::SBOX_W-1] ? wsd_pkg::SBOX_W'(-box_q) : box_q;
  assign qbox_mag = qbox_q[wsd_pkg::QBOX_W-1] ? wsd_pkg::QBOX_W'(-qbox_q) : qbox_q;

  always_comb begin
    div_in_d       = '0;
    div_in_d.vld   = vld1_q;
    div_in_d.zero  = zero_q;
    div_in_d.neg_q = qbox_q[wsd_pkg::QBOX_W-1];
    div_in_d.sacc  = wsd_pkg::QMAG_W'(box_mag[wsd_pkg::SMAG_W-1:0]);
    div_in_d.qacc  = qbox_mag[wsd_pkg::QMAG_W-1:0];
    div_in_d.n     = n_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pipe[0] <= '0;
    end else begin
      div_pipe[0] <= div_in_d;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar i = 0; i < wsd_pkg::DIV_STAGES; i++) begin : g_div
    wsd_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (div_pipe[i]),
      .q_o    (div_pipe[i+1])
    );
  end

  wsd_pkg::div_t div_out;
  assign div_out = div_pipe[wsd_pkg::DIV_STAGES];

  // ---------------- mean squared ----------------
  logic                       vldm_q, onem_q;
  logic [wsd_pkg::MM_W-1:0]   mm_q;
  logic [wsd_pkg::QMAG_W-1:0] qm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldm_q <= 1'b0;
    end else begin
      vldm_q <= div_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    onem_q <= div_out.zero || div_out.neg_q;
    mm_q   <= wsd_pkg::MM_W'(div_out.sacc[wsd_pkg::SMAG_W-1:0])
            * wsd_pkg::MM_W'(div_out.sacc[wsd_pkg::SMAG_W-1:0]);
    qm_q   <= div_out.qacc;
  end

  // ---------------- variance ----------------
  logic                               vldv_q, onev_q;
  logic signed [wsd_pkg::DIFF_W-1:0]  var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldv_q <= 1'b0;
    end else begin
      vldv_q <= vldm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    onev_q <= onem_q;
    var_q  <= $signed(wsd_pkg::DIFF_W'(qm_q)) - $signed(wsd_pkg::DIFF_W'(mm_q));
  end

  // ---------------- classify, seed the root ----------------
  wsd_pkg::sq_t sq_pipe [wsd_pkg::SQRT_STAGES+1];
  wsd_pkg::sq_t sq_in_d;

  always_comb begin
    sq_in_d     = '0;
    sq_in_d.vld = vldv_q;
    sq_in_d.one = onev_q || (var_q <= $signed(wsd_pkg::DIFF_W'(0)));
    sq_in_d.sat = !var_q[wsd_pkg::DIFF_W-1] && (var_q >= $signed(wsd_pkg::SAT_LIMIT));
    sq_in_d.v   = var_q[wsd_pkg::VAR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_pipe[0] <= '0;
    end else begin
      sq_pipe[0] <= sq_in_d;
    end
  end

  // ---------------- root: one bit per stage, MSB first ----------------
  for (genvar k = 0; k < wsd_pkg::SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [wsd_pkg::DEV_W-1:0] Trial =
      wsd_pkg::DEV_W'(1) << (wsd_pkg::DEV_W - 1 - k);
    wsd_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .trial_i (Trial),
      .d_i     (sq_pipe[k]),
      .q_o     (sq_pipe[k+1])
    );
  end

  // ---------------- output register ----------------
  wsd_pkg::sq_t              sq_out;
  logic                      done_q;
  logic [wsd_pkg::DEV_W-1:0] dev_q, dev_d;

  assign sq_out = sq_pipe[wsd_pkg::SQRT_STAGES];

  always_comb begin
    if (sq_out.one) begin
      dev_d = wsd_pkg::DEV_ONE;
    end else if (sq_out.sat) begin
      dev_d = wsd_pkg::DEV_MAX;
    end else begin
      dev_d = sq_out.r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sq_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    dev_q <= dev_d;
  end

  assign done_o      = done_q;
  assign deviation_o = dev_q;

endmodule

// ===== hdl/wsd_div_stage.sv =====
`timescale 1ns / 1ps
// One restoring division step for the box sum and squared sum lanes.
module wsd_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsd_pkg::div_t d_i,
  output wsd_pkg::div_t q_o
);

  wsd_pkg::div_t q_q, q_d;
  logic [wsd_pkg::N_W:0] s_trial, q_trial;
  logic                  s_ge, q_ge;

  assign s_trial = {d_i.srem, d_i.sacc[wsd_pkg::QMAG_W-1]};
  assign q_trial = {d_i.qrem, d_i.qacc[wsd_pkg::QMAG_W-1]};
  assign s_ge    = s_trial >= {1'b0, d_i.n};
  assign q_ge    = q_trial >= {1'b0, d_i.n};

  always_comb begin
    q_d      = d_i;
    q_d.sacc = {d_i.sacc[wsd_pkg::QMAG_W-2:0], s_ge};
    q_d.qacc = {d_i.qacc[wsd_pkg::QMAG_W-2:0], q_ge};
    q_d.srem = s_ge ? wsd_pkg::N_W'(s_trial - {1'b0, d_i.n}) : s_trial[wsd_pkg::N_W-1:0];
    q_d.qrem = q_ge ? wsd_pkg::N_W'(q_trial - {1'b0, d_i.n}) : q_trial[wsd_pkg::N_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ===== hdl/wsd_sqrt_stage.sv =====
`timescale 1ns / 1ps
// One bit of the floor square root, trial bit given by the instance.
module wsd_sqrt_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [wsd_pkg::DEV_W-1:0] trial_i,
  input  wsd_pkg::sq_t              d_i,
  output wsd_pkg::sq_t              q_o
);

  wsd_pkg::sq_t              q_q, q_d;
  logic [wsd_pkg::DEV_W-1:0] t;
  logic [wsd_pkg::VAR_W-1:0] tt;

  assign t  = d_i.r | trial_i;
  assign tt = {{wsd_pkg::DEV_W{1'b0}}, t} * {{wsd_pkg::DEV_W{1'b0}}, t};

  always_comb begin
    q_d = d_i;
    if (tt <= d_i.v) begin
      q_d.r = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule
